FILE: design/mhtq_pkg.sv
// Shared types, codes and widths for the min-heap timer queue.
package mhtq_pkg;

	localparam int CMD_W  = 3;
	localparam int ID_W   = 10;
	localparam int TMO_W  = 31;
	localparam int TIME_W = 48;
	localparam int DLY_W  = 32;
	localparam int EV_W   = 2;
	localparam int ST_W   = 2;
	localparam int SLOT_W = 6;

	localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIRE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	localparam logic [EV_W-1:0] EV_DONE    = 2'd0;
	localparam logic [EV_W-1:0] EV_EXPIRED = 2'd1;
	localparam logic [EV_W-1:0] EV_FIRED   = 2'd2;
	localparam logic [EV_W-1:0] EV_DELAY   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

	localparam logic [DLY_W-1:0] DLY_EMPTY = 32'hFFFF_FFFF;
	localparam logic [DLY_W-1:0] DLY_SAT   = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] exp;
	} entry_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_MAP, RD_ROOT, RD_LAST, RD_KIDS, RD_PARENT
	} rd_sel_t;

	typedef enum logic [1:0] {WR_NONE, WR_KID, WR_PARENT, WR_CUR} hwr_t;
	typedef enum logic [1:0] {CUR_HOLD, CUR_INPUT, CUR_LAST} cur_op_t;
	typedef enum logic [2:0] {
		IDX_HOLD, IDX_SLOT, IDX_ZERO, IDX_COUNT, IDX_KID, IDX_PARENT
	} idx_op_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC, CNT_DEC} cnt_op_t;
	typedef enum logic [2:0] {
		RES_HOLD, RES_OK, RES_NOTFOUND, RES_FULL, RES_FIRED, RES_EXPIRED,
		RES_DELAY, RES_EMPTY
	} res_op_t;

	typedef struct packed {
		logic    ld_in;
		rd_sel_t rd_sel;
		hwr_t    hwr;
		cur_op_t cur_op;
		idx_op_t idx_op;
		cnt_op_t cnt_op;
		res_op_t res_op;
		logic    emit;
		logic    clr_wr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] count;
		logic              in_range;
		logic              known;
		logic              full;
		logic              slot_lt_last;
		logic              count_gt1;
		logic              count_zero;
		logic              kids_exist;
		logic              sink_stop;
		logic              parent_less;
		logic              idx_zero;
		logic              root_expired;
		logic              moved;
		logic              out_free;
		logic              clr_done;
	} dp_stat_t;

endpackage

FILE: design/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: controller plus datapath.
// Flow: clear and unknown commands go from decode straight to the result; add, adjust and
// fire look up the id map, then move the entry one heap level at a time; tick reports empty or the delay.
// Tick: each expired timer is emitted, then the last entry is sunk from the root (not for the last one).
// Throughput: one transaction at a time; s_tready rises at the same edge at which the final result
// enters the output register. Sift cost: one heap read, compare and write per level.
// Reset: async active low; then a pass zeroes every id map entry before s_tready rises.
module min_heap_timer_queue #(
	parameter int CAPACITY = 32,
	parameter int ID_LIMIT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// timer_id[9:0], timeout_ms[40:10], now_ms[88:41], zero pad above
	input  logic [95:0] s_tdata,
	// command[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// fired_id[9:0], next_delay_ms[41:10], status[43:42], zero pad above
	output logic [47:0] m_tdata,
	// event_res[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import mhtq_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  st;

	// Sequencer: decode, id lookup and check, sift down/up loops, tick loop.
	mhtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Heap RAM (id + expiry), id-to-slot map RAM, hole registers, result register.
	// An id is live only when its map slot is below the count and the heap
	// entry there holds the same id, so clear-all only resets the count.
	mhtq_dp #(
		.CAPACITY (CAPACITY),
		.ID_LIMIT (ID_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// heap never grows past its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= SLOT_W'(CAPACITY))
		else $error("heap count above capacity");

	// one transaction in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// expired events are never the final result of a transaction
	a_expired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_EXPIRED) |-> !m_tlast)
		else $error("expired event marked last");

	// every other event closes its transaction
	a_other_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != EV_EXPIRED) |-> m_tlast)
		else $error("final event missing last");
endmodule

FILE: design/mhtq_ram.sv
// Generic RAM: one write port, two registered read ports.
module mhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

FILE: design/mhtq_ctrl.sv
// Sequencer for the timer queue: decode, lookup, sift loops, tick loop, result emit.
module mhtq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  mhtq_pkg::dp_stat_t  st,
	output mhtq_pkg::ctrl_cmd_t cmd
);
	import mhtq_pkg::*;

	typedef enum logic [14:0] {
		S_CLR    = 15'b000000000000001,
		S_IDLE   = 15'b000000000000010,
		S_DEC    = 15'b000000000000100,
		S_MAP    = 15'b000000000001000,
		S_VER    = 15'b000000000010000,
		S_RM_LD  = 15'b000000000100000,
		S_SK_RD  = 15'b000000001000000,
		S_SK_CMP = 15'b000000010000000,
		S_RS_RD  = 15'b000000100000000,
		S_RS_CMP = 15'b000001000000000,
		S_PLACE  = 15'b000010000000000,
		S_TK_RD  = 15'b000100000000000,
		S_TK_CHK = 15'b001000000000000,
		S_TK_OUT = 15'b010000000000000,
		S_EMIT   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				priority if (st.cmd == CMD_ADD || st.cmd == CMD_ADJUST ||
				             st.cmd == CMD_FIRE) begin
					state_d = S_MAP;
				end else if (st.cmd == CMD_TICK) begin
					state_d = S_TK_RD;
				end else if (st.cmd == CMD_CLEAR) begin
					cmd.cnt_op = CNT_CLR;
					cmd.res_op = RES_OK;
					state_d    = S_EMIT;
				end else begin
					cmd.res_op = RES_OK;
					state_d    = S_EMIT;
				end
			end
			S_MAP: begin
				cmd.rd_sel = RD_MAP;
				state_d    = S_VER;
			end
			S_VER: begin
				priority if (st.cmd == CMD_ADD && !st.in_range) begin
					cmd.res_op = RES_NOTFOUND;
					state_d    = S_EMIT;
				end else if ((st.cmd == CMD_ADD || st.cmd == CMD_ADJUST) && st.known) begin
					cmd.res_op = RES_OK;
					cmd.cur_op = CUR_INPUT;
					cmd.idx_op = IDX_SLOT;
					state_d    = S_SK_RD;
				end else if (st.cmd == CMD_ADD && st.full) begin
					cmd.res_op = RES_FULL;
					state_d    = S_EMIT;
				end else if (st.cmd == CMD_ADD) begin
					cmd.res_op = RES_OK;
					cmd.cur_op = CUR_INPUT;
					cmd.idx_op = IDX_COUNT;
					cmd.cnt_op = CNT_INC;
					state_d    = S_RS_RD;
				end else if (!st.known) begin
					cmd.res_op = RES_NOTFOUND;
					state_d    = S_EMIT;
				end else if (st.cmd == CMD_FIRE) begin
					cmd.res_op = RES_FIRED;
					cmd.idx_op = IDX_SLOT;
					if (st.slot_lt_last) begin
						cmd.rd_sel = RD_LAST;
						state_d    = S_RM_LD;
					end else begin
						cmd.cnt_op = CNT_DEC;
						state_d    = S_EMIT;
					end
				end else begin
					cmd.res_op = RES_OK;
					state_d    = S_EMIT;
				end
			end
			S_RM_LD: begin
				cmd.cur_op = CUR_LAST;
				cmd.cnt_op = CNT_DEC;
				state_d    = S_SK_RD;
			end
			S_SK_RD: begin
				priority if (st.kids_exist) begin
					cmd.rd_sel = RD_KIDS;
					state_d    = S_SK_CMP;
				end else if (st.moved) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_RS_RD;
				end
			end
			S_SK_CMP: begin
				priority if (!st.sink_stop) begin
					cmd.hwr    = WR_KID;
					cmd.idx_op = IDX_KID;
					state_d    = S_SK_RD;
				end else if (st.moved) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_RS_RD;
				end
			end
			S_RS_RD: begin
				if (st.idx_zero) begin
					state_d = S_PLACE;
				end else begin
					cmd.rd_sel = RD_PARENT;
					state_d    = S_RS_CMP;
				end
			end
			S_RS_CMP: begin
				if (st.parent_less) begin
					state_d = S_PLACE;
				end else begin
					cmd.hwr    = WR_PARENT;
					cmd.idx_op = IDX_PARENT;
					state_d    = S_RS_RD;
				end
			end
			S_PLACE: begin
				cmd.hwr = WR_CUR;
				state_d = (st.cmd == CMD_TICK) ? S_TK_RD : S_EMIT;
			end
			S_TK_RD: begin
				if (st.count_zero) begin
					cmd.res_op = RES_EMPTY;
					state_d    = S_EMIT;
				end else begin
					cmd.rd_sel = RD_ROOT;
					state_d    = S_TK_CHK;
				end
			end
			S_TK_CHK: begin
				if (st.root_expired) begin
					cmd.res_op = RES_EXPIRED;
					state_d    = S_TK_OUT;
				end else begin
					cmd.res_op = RES_DELAY;
					state_d    = S_EMIT;
				end
			end
			S_TK_OUT: begin
				if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.idx_op = IDX_ZERO;
					if (st.count_gt1) begin
						cmd.rd_sel = RD_LAST;
						state_d    = S_RM_LD;
					end else begin
						cmd.cnt_op = CNT_DEC;
						state_d    = S_TK_RD;
					end
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: design/mhtq_dp.sv
// Datapath: item registers, heap and id-map RAMs, sift hole, result register.
module mhtq_dp #(
	parameter int CAPACITY = 32,
	parameter int ID_LIMIT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mhtq_pkg::ctrl_cmd_t cmd,
	output mhtq_pkg::dp_stat_t  st,
	input  logic [95:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);
	import mhtq_pkg::*;

	localparam int HAW = $clog2(CAPACITY);
	localparam int MAW = $clog2(ID_LIMIT);
	localparam int EW  = ID_W + TIME_W;

	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] exp_q, now_q;
	logic [SLOT_W-1:0] slot_q, count_q, idx_q;
	logic              moved_q;
	entry_t            cur_q;
	logic [MAW-1:0]    clr_ptr_q;

	logic [EV_W-1:0]   res_ev_q;
	logic [ID_W-1:0]   res_id_q;
	logic [DLY_W-1:0]  res_dly_q;
	logic [ST_W-1:0]   res_st_q;
	logic              res_last_q;

	logic              out_valid_q;
	logic [EV_W-1:0]   out_ev_q;
	logic [ID_W-1:0]   out_id_q;
	logic [DLY_W-1:0]  out_dly_q;
	logic [ST_W-1:0]   out_st_q;
	logic              out_last_q;

	entry_t            hrd_a, hrd_b, kid, hwdata;
	logic [EW-1:0]     hrd_a_raw, hrd_b_raw;
	logic [SLOT_W-1:0] mrd, parent, last_slot, kid_idx, hsel;
	logic [SLOT_W:0]   kid_a, kid_b;
	logic              use_b, hwe, mwe, out_free;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] diff;
	logic [DLY_W-1:0]  dly;
	logic [MAW-1:0]    maddr_w;
	logic [SLOT_W-1:0] mwdata;

	assign hrd_a = entry_t'(hrd_a_raw);
	assign hrd_b = entry_t'(hrd_b_raw);

	// sift geometry
	assign kid_a     = {idx_q, 1'b1};
	assign kid_b     = kid_a + 1'b1;
	assign use_b     = (kid_b < {1'b0, count_q}) && (hrd_b.exp < hrd_a.exp);
	assign kid       = use_b ? hrd_b : hrd_a;
	assign kid_idx   = use_b ? kid_b[SLOT_W-1:0] : kid_a[SLOT_W-1:0];
	assign parent    = (idx_q - 1'b1) >> 1;
	assign last_slot = count_q - 1'b1;

	// next-delay, saturated to the positive range of the field
	assign diff = hrd_a.exp - now_q;
	assign dly  = (|diff[TIME_W-1:DLY_W-1]) ? DLY_SAT : {1'b0, diff[DLY_W-2:0]};

	assign sum = {1'b0, s_tdata[88:41]} + (TIME_W+1)'(s_tdata[40:10]);

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		st              = '0;
		st.cmd          = cmd_q;
		st.count        = count_q;
		st.in_range     = (32'(id_q) < 32'(ID_LIMIT));
		// map entry is trusted only if the heap slot points back at this id
		st.known        = st.in_range && (slot_q < count_q) && (hrd_a.id == id_q);
		st.full         = (32'(count_q) >= 32'(CAPACITY));
		st.slot_lt_last = (slot_q < last_slot);
		st.count_gt1    = (count_q > SLOT_W'(1));
		st.count_zero   = (count_q == '0);
		st.kids_exist   = (kid_a < {1'b0, count_q});
		st.sink_stop    = (cur_q.exp < kid.exp);
		st.parent_less  = (hrd_a.exp < cur_q.exp);
		st.idx_zero     = (idx_q == '0);
		st.root_expired = (hrd_a.exp <= now_q);
		st.moved        = moved_q;
		st.out_free     = out_free;
		st.clr_done     = (clr_ptr_q == MAW'(ID_LIMIT - 1));
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_MAP:    hsel = mrd;
			RD_ROOT:   hsel = '0;
			RD_LAST:   hsel = last_slot;
			RD_KIDS:   hsel = kid_a[SLOT_W-1:0];
			RD_PARENT: hsel = parent;
			default:   hsel = idx_q;
		endcase
	end

	always_comb begin
		unique case (cmd.hwr)
			WR_KID:    hwdata = kid;
			WR_PARENT: hwdata = hrd_a;
			default:   hwdata = cur_q;
		endcase
	end

	assign hwe     = (cmd.hwr != WR_NONE);
	assign mwe     = hwe || cmd.clr_wr;
	assign maddr_w = cmd.clr_wr ? clr_ptr_q : MAW'(hwdata.id);
	assign mwdata  = cmd.clr_wr ? '0 : idx_q;

	mhtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
		.clk     (clk),
		.we      (hwe),
		.waddr   (HAW'(idx_q)),
		.wdata   (EW'(hwdata)),
		.raddr_a (HAW'(hsel)),
		.rdata_a (hrd_a_raw),
		.raddr_b (HAW'(kid_b)),
		.rdata_b (hrd_b_raw)
	);

	mhtq_ram #(.WIDTH(SLOT_W), .DEPTH(ID_LIMIT)) u_map (
		.clk     (clk),
		.we      (mwe),
		.waddr   (maddr_w),
		.wdata   (mwdata),
		.raddr_a (MAW'(id_q)),
		.rdata_a (mrd),
		.raddr_b (MAW'(id_q)),
		.rdata_b ()
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			clr_ptr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				CNT_CLR: count_q <= '0;
				CNT_INC: count_q <= count_q + 1'b1;
				CNT_DEC: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (cmd.clr_wr) clr_ptr_q <= clr_ptr_q + 1'b1;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q <= s_tuser;
			id_q  <= s_tdata[9:0];
			now_q <= s_tdata[88:41];
			exp_q <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		end
		if (cmd.rd_sel == RD_MAP) slot_q <= mrd;

		unique case (cmd.cur_op)
			CUR_INPUT: begin
				cur_q.id  <= id_q;
				cur_q.exp <= exp_q;
				moved_q   <= 1'b0;
			end
			CUR_LAST: begin
				cur_q   <= hrd_a;
				moved_q <= 1'b0;
			end
			default: ;
		endcase

		unique case (cmd.idx_op)
			IDX_SLOT:   idx_q <= slot_q;
			IDX_ZERO:   idx_q <= '0;
			IDX_COUNT:  idx_q <= count_q;
			IDX_KID: begin
				idx_q   <= kid_idx;
				moved_q <= 1'b1;
			end
			IDX_PARENT: idx_q <= parent;
			default: ;
		endcase

		unique case (cmd.res_op)
			RES_OK, RES_NOTFOUND, RES_FULL: begin
				res_ev_q   <= EV_DONE;
				res_id_q   <= '0;
				res_dly_q  <= '0;
				res_last_q <= 1'b1;
				res_st_q   <= (cmd.res_op == RES_OK) ? ST_OK :
				              (cmd.res_op == RES_FULL) ? ST_FULL : ST_NOTFOUND;
			end
			RES_FIRED: begin
				res_ev_q   <= EV_FIRED;
				res_id_q   <= id_q;
				res_dly_q  <= '0;
				res_st_q   <= ST_OK;
				res_last_q <= 1'b1;
			end
			RES_EXPIRED: begin
				res_ev_q   <= EV_EXPIRED;
				res_id_q   <= hrd_a.id;
				res_dly_q  <= '0;
				res_st_q   <= ST_OK;
				res_last_q <= 1'b0;
			end
			RES_DELAY, RES_EMPTY: begin
				res_ev_q   <= EV_DELAY;
				res_id_q   <= '0;
				res_dly_q  <= (cmd.res_op == RES_EMPTY) ? DLY_EMPTY : dly;
				res_st_q   <= ST_OK;
				res_last_q <= 1'b1;
			end
			default: ;
		endcase

		if (cmd.emit) begin
			out_ev_q   <= res_ev_q;
			out_id_q   <= res_id_q;
			out_dly_q  <= res_dly_q;
			out_st_q   <= res_st_q;
			out_last_q <= res_last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_st_q, out_dly_q, out_id_q};
	assign m_tuser  = out_ev_q;
	assign m_tlast  = out_last_q;
endmodule
